// ===== sv/eyo_pkg.sv =====
// Shared types, constants and rounding helper for the encoder/yaw odometry block.
// No dependencies; imported by every module of the block.
package eyo_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_M5,
		ST_M6,
		ST_M7,
		ST_M8,
		ST_PUSH
	} eyo_state_t;

	typedef enum logic {
		REG_RADIUS_LEFT  = 1'b0,
		REG_RADIUS_RIGHT = 1'b1
	} eyo_reg_t;

	localparam int ATAN_DEPTH = 24;
	localparam int ZW = 32;   // CORDIC phase width
	localparam int XW = 34;   // CORDIC vector width (Q30 plus headroom)
	localparam int AW = 34;   // multiplier operand A width
	localparam int BW = 20;   // multiplier operand B width
	localparam int PW = AW + BW;

	localparam logic signed [XW-1:0] CORDIC_KINV_Q30 = 34'sd652032874;
	localparam logic signed [BW-1:0] GAIN_Q24 = 20'sd291169;
	localparam logic signed [ZW-1:0] QUARTER_TURN = 32'sh4000_0000;
	localparam logic signed [15:0] Q15_MAX = 16'sd32767;
	localparam logic signed [16:0] HALF_TURN = 17'sd32768;
	localparam logic signed [16:0] FULL_TURN = 17'sd65536 - 17'sd1;

	typedef logic signed [ZW-1:0] atan_tab_t [ATAN_DEPTH];
	localparam atan_tab_t ATAN_TAB = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
		32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
		32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
		32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
		32'sd652, 32'sd326, 32'sd163, 32'sd81
	};

	// Shift right by k, rounding half away from zero.
	function automatic logic signed [PW:0] rnd_shift(input logic signed [PW:0] v,
		input int unsigned k);
		logic [PW:0] mag;
		logic [PW:0] half;
		logic [PW:0] r;
		begin
			half = (PW+1)'(1) << (k - 1);
			mag  = v[PW] ? (PW+1)'(-v) : (PW+1)'(v);
			r    = (mag + half) >> k;
			rnd_shift = v[PW] ? -$signed(r) : $signed(r);
		end
	endfunction

endpackage

// ===== sv/eyo_cordic.sv =====
// Iterative rotation-mode CORDIC: one shift-add micro-rotation per cycle.
// Depends on eyo_pkg for widths, gain constant and the arctangent table.
module eyo_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [eyo_pkg::ZW-1:0] z0,
	output logic                        done,
	output logic signed [eyo_pkg::XW-1:0] x,
	output logic signed [eyo_pkg::XW-1:0] y
);
	import eyo_pkg::*;

	localparam int CW = $clog2(ATAN_DEPTH);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic signed [XW-1:0] xs, ys;

	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_KINV_Q30;
			y_q <= '0;
			z_q <= z0;
		end else if (busy_q) begin
			if (!z_q[ZW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ATAN_TAB[cnt_q];
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ATAN_TAB[cnt_q];
			end
		end
	end

	assign done = done_q;
	assign x    = x_q;
	assign y    = y_q;

endmodule

// ===== sv/eyo_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on eyo_pkg for operand and product widths.
module eyo_mul (
	input  logic                        clk,
	input  logic signed [eyo_pkg::AW-1:0] a,
	input  logic signed [eyo_pkg::BW-1:0] b,
	output logic signed [eyo_pkg::PW-1:0] p
);
	import eyo_pkg::*;

	logic signed [PW-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= PW'(a) * PW'(b);
	end

	assign p = p_q;

endmodule

// ===== sv/encoder_yaw_odometry_unit.sv =====
// Top level of the encoder/yaw dead-reckoning odometry block.
// Depends on eyo_pkg, eyo_cordic and eyo_mul.
//
// Usage:
//   Input beats on s_t* carry two absolute wheel angles and an IMU yaw.
//   Each input beat yields exactly one output beat on m_t* holding the
//   saturating Q24.8 X/Y position after that tick.
//   Radii are written over the APB port (0x0 left, 0x4 right) while idle.
// Timing:
//   Each beat runs through the iterative CORDIC (one micro-rotation a cycle)
//   and then through eight passes of the shared multiplier before m_tvalid rises.
//   s_tready is high only while the sequencer idles, so a new beat is taken only
//   once the previous result has left the sequencer for the output register.
// Reset:
//   arst_n clears offsets, history, position and sets both radii to 1.
// Stall:
//   A finished result sits in the output register; the next beat may be
//   accepted meanwhile, and its result waits in the sequencer until the
//   output register is free. No beat is ever dropped.
module encoder_yaw_odometry_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // left_angle[15:0], right_angle[31:16], yaw_angle[47:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // pos_x[31:0], pos_y[63:32]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import eyo_pkg::*;

	// configuration
	logic [15:0] radius_left_q, radius_right_q;
	logic        cfg_wr;

	// persistent odometry state
	logic               cap_q;
	logic [15:0]        off_l_q, off_r_q;
	logic signed [15:0] off_yaw_q;
	logic signed [16:0] prev_yaw_q;
	logic [15:0]        prev_l_q, prev_r_q;
	logic signed [31:0] acc_x_q, acc_y_q;

	// per-item working registers
	eyo_state_t         state_q, state_d;
	logic signed [17:0] u_q, v_q;
	logic [1:0]         quad_q;
	logic signed [15:0] c_q, s_q;
	logic signed [33:0] t_q, bx_q, by_q;
	logic signed [29:0] sx_q, sy_q;

	// output register
	logic        out_valid_q;
	logic [63:0] out_data_q;

	// front end
	logic [15:0]        in_l, in_r;
	logic signed [15:0] in_yaw;
	logic [15:0]        eff_off_l, eff_off_r;
	logic signed [15:0] eff_off_yaw;
	logic signed [16:0] rel_yaw;
	logic signed [16:0] yaw_sum;
	logic [15:0]        rel_l, rel_r;
	logic signed [16:0] dl_raw, dr_raw, dl, dr;
	logic [1:0]         quad0;
	logic signed [ZW-1:0] phase_r, z0;
	logic               accept;

	// CORDIC and multiplier
	logic                 cordic_done;
	logic signed [XW-1:0] cx, cy;
	logic signed [15:0]   c0, s0;
	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] prod;
	logic signed [PW:0]   prod_r24, prod_r15;
	logic signed [PW:0]   cx_r, cy_r;
	logic signed [32:0]   acc_sum;
	logic signed [31:0]   acc_sel;
	logic signed [31:0]   acc_new;

	assign in_l   = s_tdata[15:0];
	assign in_r   = s_tdata[31:16];
	assign in_yaw = s_tdata[47:32];
	assign accept = s_tvalid && s_tready;

	// APB: always ready, write lands on the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	always_comb begin
		case (eyo_reg_t'(paddr[2]))
			REG_RADIUS_LEFT:  prdata = {16'h0, radius_left_q};
			REG_RADIUS_RIGHT: prdata = {16'h0, radius_right_q};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_left_q  <= 16'd1;
			radius_right_q <= 16'd1;
		end else if (cfg_wr) begin
			if (eyo_reg_t'(paddr[2]) == REG_RADIUS_LEFT)
				radius_left_q <= pwdata[15:0];
			else
				radius_right_q <= pwdata[15:0];
		end
	end

	// Offsets are taken from the current beat until a nonzero yaw is seen.
	assign eff_off_l   = cap_q ? off_l_q   : in_l;
	assign eff_off_r   = cap_q ? off_r_q   : in_r;
	assign eff_off_yaw = cap_q ? off_yaw_q : in_yaw;

	assign rel_yaw = 17'(in_yaw) - 17'(eff_off_yaw);
	assign yaw_sum = prev_yaw_q + rel_yaw;
	assign rel_l   = in_l - eff_off_l;
	assign rel_r   = in_r - eff_off_r;
	assign dl_raw  = $signed({1'b0, rel_l}) - $signed({1'b0, prev_l_q});
	assign dr_raw  = $signed({1'b0, prev_r_q}) - $signed({1'b0, rel_r});

	// Wrap into one half turn each way; an exact half turn keeps its sign.
	always_comb begin
		dl = dl_raw;
		if (dl_raw > HALF_TURN)       dl = dl_raw - FULL_TURN - 17'sd1;
		else if (dl_raw < -HALF_TURN) dl = dl_raw + FULL_TURN + 17'sd1;
		dr = dr_raw;
		if (dr_raw > HALF_TURN)       dr = dr_raw - FULL_TURN - 17'sd1;
		else if (dr_raw < -HALF_TURN) dr = dr_raw + FULL_TURN + 17'sd1;
	end

	// Mean yaw in half units -> 32-bit phase; fold into +-45 degrees.
	assign phase_r = $signed({2'b00, yaw_sum[14:0], 15'h0});
	assign z0      = yaw_sum[14] ? phase_r - QUARTER_TURN : phase_r;
	assign quad0   = yaw_sum[14] ? yaw_sum[16:15] + 2'd1 : yaw_sum[16:15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= 1'b0;
			off_l_q    <= '0;
			off_r_q    <= '0;
			off_yaw_q  <= '0;
			prev_yaw_q <= '0;
			prev_l_q   <= '0;
			prev_r_q   <= '0;
		end else if (accept) begin
			if (!cap_q) begin
				off_l_q   <= in_l;
				off_r_q   <= in_r;
				off_yaw_q <= in_yaw;
				cap_q     <= (in_yaw != 16'sd0);
			end
			prev_yaw_q <= rel_yaw;
			prev_l_q   <= rel_l;
			prev_r_q   <= rel_r;
		end
	end

	eyo_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.z0    (z0),
		.done  (cordic_done),
		.x     (cx),
		.y     (cy)
	);

	// Round to Q1.15 and clamp to the symmetric range.
	assign cx_r = rnd_shift((PW+1)'(cx), 15);
	assign cy_r = rnd_shift((PW+1)'(cy), 15);
	always_comb begin
		c0 = cx_r[15:0];
		if (cx_r > (PW+1)'(Q15_MAX))  c0 = Q15_MAX;
		if (cx_r < -(PW+1)'(Q15_MAX)) c0 = -Q15_MAX;
		s0 = cy_r[15:0];
		if (cy_r > (PW+1)'(Q15_MAX))  s0 = Q15_MAX;
		if (cy_r < -(PW+1)'(Q15_MAX)) s0 = -Q15_MAX;
	end

	// Operand select for the shared multiplier, one product per state.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_M0: begin mul_a = AW'(c_q);  mul_b = BW'(u_q); end
			ST_M1: begin mul_a = AW'(s_q);  mul_b = BW'(v_q); end
			ST_M2: begin mul_a = AW'(c_q);  mul_b = BW'(v_q); end
			ST_M3: begin mul_a = AW'(s_q);  mul_b = BW'(u_q); end
			ST_M4: begin mul_a = bx_q;      mul_b = GAIN_Q24; end
			ST_M5: begin mul_a = by_q;      mul_b = GAIN_Q24; end
			ST_M6: begin mul_a = AW'(sx_q); mul_b = $signed({4'h0, radius_left_q}); end
			ST_M7: begin mul_a = AW'(sy_q); mul_b = $signed({4'h0, radius_right_q}); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	eyo_mul u_mul (
		.clk(clk),
		.a  (mul_a),
		.b  (mul_b),
		.p  (prod)
	);

	assign prod_r24 = rnd_shift((PW+1)'(prod), 24);
	assign prod_r15 = rnd_shift((PW+1)'(prod), 15);

	// Saturating accumulate; M7 finishes X, M8 finishes Y.
	assign acc_sel = (state_q == ST_M7) ? acc_x_q : acc_y_q;
	assign acc_sum = 33'(acc_sel) + 33'(prod_r15);
	always_comb begin
		acc_new = acc_sum[31:0];
		if (acc_sum > 33'sh0_7FFF_FFFF)  acc_new = 32'sh7FFF_FFFF;
		if (acc_sum < -33'sh0_8000_0000) acc_new = 32'sh8000_0000;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = ST_CORDIC;
			end
			ST_CORDIC: if (cordic_done) state_d = ST_M0;
			ST_M0: state_d = ST_M1;
			ST_M1: state_d = ST_M2;
			ST_M2: state_d = ST_M3;
			ST_M3: state_d = ST_M4;
			ST_M4: state_d = ST_M5;
			ST_M5: state_d = ST_M6;
			ST_M6: state_d = ST_M7;
			ST_M7: state_d = ST_M8;
			ST_M8: state_d = ST_PUSH;
			ST_PUSH: if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			u_q    <= 18'(dr) - 18'(dl);
			v_q    <= 18'(dr) + 18'(dl);
			quad_q <= quad0;
		end
		if (state_q == ST_CORDIC && cordic_done) begin
			case (quad_q)
				2'd0: begin c_q <= c0;  s_q <= s0;  end
				2'd1: begin c_q <= -s0; s_q <= c0;  end
				2'd2: begin c_q <= -c0; s_q <= -s0; end
				default: begin c_q <= s0; s_q <= -c0; end
			endcase
		end
		case (state_q)
			ST_M1: t_q  <= prod[33:0];
			ST_M2: bx_q <= t_q - prod[33:0];
			ST_M3: t_q  <= prod[33:0];
			ST_M4: by_q <= t_q + prod[33:0];
			ST_M5: sx_q <= prod_r24[29:0];
			ST_M6: sy_q <= prod_r24[29:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
		end else if (state_q == ST_M7) begin
			acc_x_q <= acc_new;
		end else if (state_q == ST_M8) begin
			acc_y_q <= acc_new;
		end
	end

	// Output register: hold until taken, load from the sequencer when free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_PUSH && (!out_valid_q || m_tready)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH && (!out_valid_q || m_tready))
			out_data_q <= {acc_y_q, acc_x_q};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input taken while a beat is in flight");

	a_cordic_done_in_cordic: assert property (@(posedge clk) disable iff (!arst_n)
		cordic_done |-> (state_q == ST_CORDIC))
		else $error("CORDIC finished outside its sequencer state");

	a_push_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH && (!out_valid_q || m_tready)) |=> m_tvalid)
		else $error("finished result not presented");
`endif

endmodule

// ===== verif/encoder_yaw_odometry_checker.sv =====
// Checker for the encoder/yaw odometry block: watches the input and output beats,
// predicts each position from its own odometry model and compares. Depends on eyo_pkg.
`timescale 1ns / 100ps

module encoder_yaw_odometry_checker #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending
);
	import eyo_pkg::*;

	localparam longint GAIN = 291169;
	localparam longint KINV = 652032874;

	typedef struct {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} position_t;

	position_t pos_queue[$];

	logic [15:0]        rad_l, rad_r;
	bit                 captured;
	logic [15:0]        off_l, off_r;
	int                 off_yaw, last_yaw;
	logic [15:0]        last_l, last_r;
	longint             sum_x, sum_y;

	function automatic longint sra(longint v, int k);
		return v >>> k;
	endfunction

	function automatic longint round_shift(longint v, int k);
		longint half;
		half = longint'(1) << (k - 1);
		if (v >= 0)
			return (v + half) >>> k;
		return -((-v + half) >>> k);
	endfunction

	function automatic longint clip_q15(longint v);
		longint r;
		r = round_shift(v, 15);
		if (r > 32767) r = 32767;
		if (r < -32767) r = -32767;
		return r;
	endfunction

	function automatic int wrap_turn(int d);
		if (d > 32768) d -= 65536;
		if (d < -32768) d += 65536;
		return d;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Sine and cosine of a 32 bit phase, quadrant folded then CORDIC in Q30.
	task automatic sin_cos(input logic [31:0] phase, output longint c, output longint s);
		logic [1:0] quad;
		longint z, x, y, xs, ys, cc, ss;
		quad = phase[31:30];
		x = KINV;
		y = 0;
		if (phase[29]) begin
			z = longint'({2'b00, phase[29:0]}) - 64'sh4000_0000;
			quad = quad + 2'd1;
		end else begin
			z = longint'({2'b00, phase[29:0]});
		end
		for (int i = 0; i < CORDIC_STEPS && i < ATAN_DEPTH; i++) begin
			xs = sra(x, i);
			ys = sra(y, i);
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(ATAN_TAB[i]);
			end else begin
				x += ys; y -= xs; z += longint'(ATAN_TAB[i]);
			end
		end
		cc = clip_q15(x);
		ss = clip_q15(y);
		case (quad)
			2'd0: begin c = cc;  s = ss;  end
			2'd1: begin c = -ss; s = cc;  end
			2'd2: begin c = -cc; s = -ss; end
			default: begin c = ss; s = -cc; end
		endcase
	endtask

	task automatic predict_tick(input logic [47:0] beat);
		logic [15:0] left, right, rl, rr;
		int yaw, rel_yaw, dl, dr;
		logic [31:0] phase;
		longint u, v, c, s, bx, by, sx, sy;
		left = beat[15:0];
		right = beat[31:16];
		yaw = int'($signed(beat[47:32]));
		if (!captured) begin
			off_l = left;
			off_r = right;
			off_yaw = yaw;
			if (yaw != 0) captured = 1;
		end
		rel_yaw = yaw - off_yaw;
		phase = 32'(last_yaw + rel_yaw) << 15;
		rl = left - off_l;
		rr = right - off_r;
		dl = wrap_turn(int'(rl) - int'(last_l));
		dr = wrap_turn(-(int'(rr) - int'(last_r)));
		u = dr - dl;
		v = dr + dl;
		sin_cos(phase, c, s);
		bx = c * u - s * v;
		by = c * v + s * u;
		sx = round_shift(bx * GAIN, 24);
		sy = round_shift(by * GAIN, 24);
		sum_x = clamp32(sum_x + round_shift(sx * longint'(rad_l), 15));
		sum_y = clamp32(sum_y + round_shift(sy * longint'(rad_r), 15));
		last_yaw = rel_yaw;
		last_l = rl;
		last_r = rr;
		pos_queue.push_back('{pos_x: 32'(sum_x), pos_y: 32'(sum_y)});
	endtask

	assign pending = pos_queue.size();

	always @(posedge clk or negedge arst_n) begin
		position_t want;
		if (!arst_n) begin
			rad_l = 16'd1; rad_r = 16'd1;
			captured = 0; off_l = '0; off_r = '0; off_yaw = 0; last_yaw = 0;
			last_l = '0; last_r = '0; sum_x = 0; sum_y = 0;
			fail_count = 0;
			pos_queue.delete();
		end else begin
			if (psel && penable && pwrite) begin
				case (eyo_reg_t'(paddr[2]))
					REG_RADIUS_LEFT:  rad_l = pwdata[15:0];
					REG_RADIUS_RIGHT: rad_r = pwdata[15:0];
					default: ;
				endcase
			end
			// check output before predicting, in case both land on one edge
			if (m_tvalid && m_tready) begin
				if (pos_queue.size() == 0) begin
					$error("unexpected output beat %h", m_tdata);
					fail_count++;
				end else begin
					want = pos_queue.pop_front();
					if (m_tdata[31:0] !== want.pos_x) begin
						$error("pos_x expected %0d actual %0d", want.pos_x,
							$signed(m_tdata[31:0]));
						fail_count++;
					end
					if (m_tdata[63:32] !== want.pos_y) begin
						$error("pos_y expected %0d actual %0d", want.pos_y,
							$signed(m_tdata[63:32]));
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_tick(s_tdata);
		end
	end

endmodule

// ===== verif/encoder_yaw_odometry_unit_tb.sv =====
// Testbench top for encoder_yaw_odometry_unit: drives input beats, radius writes
// and output stalls, then gives the verdict. Depends on eyo_pkg and the checker.
`timescale 1ns / 100ps

module encoder_yaw_odometry_unit_tb;
	import eyo_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // left_angle[15:0], right_angle[31:16], yaw_angle[47:32]
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // pos_x[31:0], pos_y[63:32]
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;
	bit          stall_hold;   // set by stimulus to force a long output hold-off

	// Wheel state of the simulated robot, so random ticks look like real motion.
	logic [15:0] wheel_l, wheel_r;
	logic signed [15:0] heading;

	encoder_yaw_odometry_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	encoder_yaw_odometry_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Hard limit well above the slowest correct run.
	initial begin
		#40ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	// Output side: random stalls, plus a long hold-off on request.
	initial begin
		int n;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			if (stall_hold) begin
				m_tready <= 0;
				for (int i = 0; i < 400; i++) @(posedge clk);
				stall_hold = 0;
			end
			n = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
			if (n > 0) begin
				m_tready <= 0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
		end
	end

	// Send one beat, hold it until accepted, then sometimes drop valid for a random gap.
	task automatic send_tick(input logic [15:0] l, input logic [15:0] r,
		input logic [15:0] y);
		int g;
		s_tdata  <= {y, r, l};
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
		if (g > 0) begin
			s_tvalid <= 0;
			s_tdata  <= 48'($urandom()) ^ {48{1'b1}};
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic apb_write(input eyo_reg_t idx, input logic [15:0] val);
		psel    <= 1;
		penable <= 0;
		pwrite  <= 1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom()), val};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel    <= 0;
		penable <= 0;
		pwrite  <= 0;
	endtask

	// Wait for all results, plus the block's latency so it is truly idle.
	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Random tick: mostly smooth motion, sometimes wild jumps across full range.
	task automatic random_tick();
		if ($urandom_range(0, 9) == 0) begin
			wheel_l = 16'($urandom());
			wheel_r = 16'($urandom());
			heading = 16'($urandom());
		end else begin
			wheel_l += 16'($signed(12'($urandom())));
			wheel_r += 16'($signed(12'($urandom())));
			heading += 16'($signed(11'($urandom())));
		end
		send_tick(wheel_l, wheel_r, heading);
	endtask

	initial begin
		s_tvalid = 0; s_tdata = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		stall_hold = 0;
		wheel_l = '0; wheel_r = '0; heading = '0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Capture phase: zero yaw keeps re-capturing, then a nonzero yaw latches.
		send_tick(16'h1234, 16'hFFFF, 16'h0000);
		send_tick(16'h0000, 16'h8000, 16'h0000);
		send_tick(16'hFFFF, 16'h0000, 16'h8000);
		// Extremes: half turns (sign kept), near-full wraps, yaw extremes.
		send_tick(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_tick(16'hFFFF, 16'hFFFF, 16'h8000);
		send_tick(16'h7FFF, 16'h7FFF, 16'h0000);
		send_tick(16'h8000, 16'h0000, 16'hFFFF);
		send_tick(16'h0001, 16'hFFFE, 16'h4000);
		send_tick(16'h8001, 16'h7FFE, 16'hC000);
		drain();

		// Largest radii with full-speed motion gives the largest position steps per tick.
		apb_write(REG_RADIUS_LEFT, 16'hFFFF);
		apb_write(REG_RADIUS_RIGHT, 16'hFFFF);
		for (int i = 0; i < 12; i++)
			send_tick(16'(i * 16'h7FFF), 16'(i * 16'h8001), 16'h0000);
		drain();
		// Zero radius: no motion on that axis.
		apb_write(REG_RADIUS_LEFT, 16'h0000);
		apb_write(REG_RADIUS_RIGHT, 16'h0001);
		for (int i = 0; i < 4; i++) random_tick();
		drain();

		// Random phases with several radius settings; one long output hold-off.
		for (int ph = 0; ph < 6; ph++) begin
			apb_write(REG_RADIUS_LEFT, (ph == 1) ? 16'd1 : 16'($urandom_range(1, 65535)));
			apb_write(REG_RADIUS_RIGHT, (ph == 2) ? 16'hFFFF : 16'($urandom_range(1, 65535)));
			if (ph == 3) stall_hold = 1;
			for (int i = 0; i < 140; i++) random_tick();
			drain();
		end

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
